>>> src/hrot_pkg.sv
// shared types and constants for the rgb hue rotator
`timescale 1ns / 1ps
package hrot_pkg;

  // pixel fields carried down the pipeline
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] delta;
    logic       bypass;
  } pix_t;

  // hue sector after rotation, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_UP   = 3'd0,
    SEC_GRN_DOWN = 3'd1,
    SEC_GRN_UP   = 3'd2,
    SEC_BLU_DOWN = 3'd3,
    SEC_BLU_UP   = 3'd4,
    SEC_RED_DOWN = 3'd5
  } sector_t;

  // configuration register byte addresses
  localparam logic [2:0] REG_HUE_SHIFT = 3'd0;
  localparam logic [2:0] REG_ENABLE    = 3'd4;

  // register widths
  localparam int SHIFT_W = 14;

  // floor(y / 15) = (y * RECIP_15) >> RECIP_15_SH for y below 4681
  localparam int          RECIP_15_SH = 16;
  localparam logic [12:0] RECIP_15    = 13'd4370;

  // shift reduction reciprocal precision
  localparam int SHIFT_RECIP_SH = 24;

endpackage

>>> src/hrot_cfg.sv
// configuration registers and shift reduction modulo a full turn
`timescale 1ns / 1ps
module hrot_cfg #(
  parameter int FULL = 5760,
  parameter int HW   = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic                        rot_off,
  output logic [HW-1:0]               shift_mod
);
  import hrot_pkg::*;

  localparam int          RECIP   = (1 << SHIFT_RECIP_SH) / FULL;
  localparam int          RECIP_W = $clog2(RECIP + 1);

  logic [SHIFT_W-1:0] hue_shift;
  logic               enable;
  logic               wr;

  logic [SHIFT_W-1:0]         mag;
  logic [SHIFT_W+RECIP_W-1:0] quo_full;
  logic [SHIFT_W-1:0]         mag_r;
  logic [SHIFT_W-1:0]         quo_r;
  logic                       neg_r;
  logic                       neg_rr;
  logic [SHIFT_W-1:0]         rem_r;
  logic [31:0]                rem_x;
  logic [31:0]                rem_fix;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // register writes, decoded on the word index
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift <= '0;
      enable    <= 1'b1;
    end else if (wr) begin
      if (paddr[2] == REG_ENABLE[2]) begin
        enable <= pwdata[0];
      end else begin
        hue_shift <= pwdata[SHIFT_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == REG_ENABLE[2]) begin
      prdata = {31'd0, enable};
    end else begin
      prdata = {{(32-SHIFT_W){hue_shift[SHIFT_W-1]}}, hue_shift};
    end
  end

  assign rot_off = (hue_shift == '0) || !enable;

  // magnitude and quotient estimate by reciprocal
  assign mag      = hue_shift[SHIFT_W-1] ? (~hue_shift + 1'b1) : hue_shift;
  assign quo_full = (SHIFT_W+RECIP_W)'(mag) * (SHIFT_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    mag_r <= mag;
    quo_r <= SHIFT_W'(quo_full >> SHIFT_RECIP_SH);
    neg_r <= hue_shift[SHIFT_W-1];
  end

  // remainder, at most one turn too large
  always_ff @(posedge clk) begin
    rem_r  <= SHIFT_W'(32'(mag_r) - 32'(quo_r) * 32'(FULL));
    neg_rr <= neg_r;
  end

  // correct and fold negative shifts into one turn
  always_comb begin
    rem_x = 32'(rem_r);
    if (rem_x >= 32'(FULL)) begin
      rem_x = rem_x - 32'(FULL);
    end
    rem_fix = rem_x;
    if (neg_rr && (rem_x != 32'd0)) begin
      rem_fix = 32'(FULL) - rem_x;
    end
  end

  always_ff @(posedge clk) begin
    shift_mod <= HW'(rem_fix);
  end

endmodule

>>> src/hrot_front.sv
// input stages: max, min, delta, bypass decision and hue dividend
`timescale 1ns / 1ps
module hrot_front #(
  parameter int SIXTH = 960,
  parameter int RW    = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [23:0]          in_data,
  input  logic                 rot_off,
  output logic                 out_valid,
  output hrot_pkg::pix_t       out_pix,
  output logic [RW-1:0]        out_dividend
);
  import hrot_pkg::*;

  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [14:0] delta_x100;
  logic [10:0] num;
  pix_t        pix;

  logic        a_valid;
  pix_t        a_pix;
  logic [10:0] a_num;

  assign r = in_data[7:0];
  assign g = in_data[15:8];
  assign b = in_data[23:16];

  // extremes and hue numerator, ties go to red then green
  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta      = mx - mn;
    delta_x100 = 15'(delta) * 15'd100;
    if (mx == r) begin
      num = 11'(delta) * 11'd6 + 11'(g) - 11'(b);
    end else if (mx == g) begin
      num = 11'(delta) * 11'd2 + 11'(b) - 11'(r);
    end else begin
      num = 11'(delta) * 11'd4 + 11'(r) - 11'(g);
    end
    pix.r      = r;
    pix.g      = g;
    pix.b      = b;
    pix.mx     = mx;
    pix.mn     = mn;
    pix.delta  = delta;
    pix.bypass = rot_off || (mx == 8'd0) || (mn == 8'd255) ||
                 (delta_x100 < 15'(mx)) || (delta == 8'd0);
  end

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix <= pix;
      a_num <= num;
    end
  end

  // stage b: scale numerator to hue units
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix      <= a_pix;
      out_dividend <= RW'(a_num) * RW'(SIXTH);
    end
  end

endmodule

>>> src/hrot_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hrot_div #(
  parameter int QW = 13,
  parameter int RW = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  hrot_pkg::pix_t       in_pix,
  input  logic [RW-1:0]        in_dividend,
  output logic                 out_valid,
  output hrot_pkg::pix_t       out_pix,
  output logic [QW-1:0]        out_quo
);
  import hrot_pkg::*;

  logic          v   [QW];
  pix_t          p   [QW];
  logic [RW-1:0] rem [QW];
  logic [QW-1:0] quo [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;

    logic          prev_v;
    pix_t          prev_p;
    logic [RW-1:0] prev_rem;
    logic [QW-1:0] prev_quo;
    logic [RW-1:0] dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign prev_v   = in_valid;
      assign prev_p   = in_pix;
      assign prev_rem = in_dividend;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_v   = v[k-1];
      assign prev_p   = p[k-1];
      assign prev_rem = rem[k-1];
      assign prev_quo = quo[k-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = RW'(prev_p.delta) << BIT;
    assign ge  = prev_rem >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p[k]   <= prev_p;
        rem[k] <= ge ? (prev_rem - dsh) : prev_rem;
        quo[k] <= prev_quo | (QW'(ge) << BIT);
      end
    end
  end

  assign out_valid = v[QW-1];
  assign out_pix   = p[QW-1];
  assign out_quo   = quo[QW-1];

endmodule

>>> src/hrot_back.sv
// back stages: rotate hue, rebuild channels, output register
`timescale 1ns / 1ps
module hrot_back #(
  parameter int F     = 4,
  parameter int SIXTH = 960,
  parameter int FULL  = 5760,
  parameter int QW    = 13,
  parameter int HW    = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  hrot_pkg::pix_t       in_pix,
  input  logic [QW-1:0]        in_quo,
  input  logic [HW-1:0]        shift_mod,
  output logic                 out_valid,
  output logic [23:0]          out_data,
  output logic                 out_flag
);
  import hrot_pkg::*;

  localparam int WW = $clog2(SIXTH + 1);
  localparam int PW = 8 + WW;

  // stage registers
  logic          v1, v2, v3, v4, v5;
  pix_t          p1, p2, p3, p4, p5;
  logic [HW-1:0] h1;
  logic [HW-1:0] h2;
  sector_t       s3, s4, s5;
  logic [WW-1:0] w3;
  logic [PW-1:0] prod4;
  logic [24:0]   yq5;

  // combinational terms
  logic [HW:0]   hsum;
  logic [HW:0]   hrot;
  sector_t       sec;
  logic [HW-1:0] t;
  logic [WW-1:0] w;
  logic [11:0]   y;
  logic [7:0]    q;
  logic [8:0]    mid_sum;
  logic [7:0]    mid;
  logic [7:0]    ro, go, bo;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  // stage 1: wrap red-sector hue into one turn
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= in_pix;
      h1 <= (in_quo >= QW'(FULL)) ? HW'(in_quo - QW'(FULL)) : HW'(in_quo);
    end
  end

  // stage 2: add the shift modulo a full turn
  always_comb begin
    hsum = (HW+1)'(h1) + (HW+1)'(shift_mod);
    hrot = (hsum >= (HW+1)'(FULL)) ? (hsum - (HW+1)'(FULL)) : hsum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2 <= p1;
      h2 <= HW'(hrot);
    end
  end

  // stage 3: sector and distance into the ramp
  always_comb begin
    if (h2 >= HW'(5 * SIXTH)) begin
      sec = SEC_RED_DOWN;
      t   = h2 - HW'(4 * SIXTH);
    end else if (h2 >= HW'(4 * SIXTH)) begin
      sec = SEC_BLU_UP;
      t   = h2 - HW'(4 * SIXTH);
    end else if (h2 >= HW'(3 * SIXTH)) begin
      sec = SEC_BLU_DOWN;
      t   = h2 - HW'(2 * SIXTH);
    end else if (h2 >= HW'(2 * SIXTH)) begin
      sec = SEC_GRN_UP;
      t   = h2 - HW'(2 * SIXTH);
    end else if (h2 >= HW'(SIXTH)) begin
      sec = SEC_GRN_DOWN;
      t   = h2;
    end else begin
      sec = SEC_RED_UP;
      t   = h2;
    end
    w = (t < HW'(SIXTH)) ? WW'(t) : WW'(HW'(2 * SIXTH) - t);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3 <= p2;
      s3 <= sec;
      w3 <= w;
    end
  end

  // stage 4: chroma times ramp position
  always_ff @(posedge clk) begin
    if (adv) begin
      p4    <= p3;
      s4    <= s3;
      prod4 <= PW'(p3.delta) * PW'(w3);
    end
  end

  // stage 5: divide by a sixth via reciprocal of fifteen
  assign y = 12'(prod4 >> (F + 2));

  always_ff @(posedge clk) begin
    if (adv) begin
      p5  <= p4;
      s5  <= s4;
      yq5 <= 25'(y) * 25'(RECIP_15);
    end
  end

  // stage 6: middle channel and channel order
  always_comb begin
    q       = 8'(yq5 >> RECIP_15_SH);
    mid_sum = 9'(p5.mn) + 9'(q);
    mid     = mid_sum[7:0];
    unique case (s5)
      SEC_RED_UP:   begin ro = p5.mx; go = mid;   bo = p5.mn; end
      SEC_GRN_DOWN: begin ro = mid;   go = p5.mx; bo = p5.mn; end
      SEC_GRN_UP:   begin ro = p5.mn; go = p5.mx; bo = mid;   end
      SEC_BLU_DOWN: begin ro = p5.mn; go = mid;   bo = p5.mx; end
      SEC_BLU_UP:   begin ro = mid;   go = p5.mn; bo = p5.mx; end
      default:      begin ro = p5.mx; go = p5.mn; bo = mid;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p5.bypass) begin
        out_data <= {p5.b, p5.g, p5.r};
      end else begin
        out_data <= {bo, go, ro};
      end
      out_flag <= p5.bypass;
    end
  end

endmodule

>>> src/rgb_hue_rotate.sv
// top level of the rgb hue rotator
// Rotates the hue of one 8-bit RGB pixel per clock by the signed hue_shift
// register (in 1/2^HUE_FRAC_BITS degree). The pipeline takes a new pixel
// every cycle unless the output stalls; the hue is found by a divider, one
// quotient bit per stage. The whole pipeline halts while the output is
// stalled. Pixels that are grey, black, white, nearly unsaturated, or that
// arrive with the block disabled or a zero shift come out unchanged with
// tuser set. Configuration goes through the register port at byte 0
// (hue_shift) and byte 4 (enable); the user must write it only while
// no pixel is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
module rgb_hue_rotate #(
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  // pixel output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic        m_tuser    // passed_through
);
  import hrot_pkg::*;

  localparam int SIXTH = 60 * (1 << HUE_FRAC_BITS);
  localparam int FULL  = 6 * SIXTH;
  localparam int QW    = $clog2(7 * SIXTH + 1);
  localparam int RW    = QW + 8;
  localparam int HW    = $clog2(FULL);

  logic          adv;
  logic          rot_off;
  logic [HW-1:0] shift_mod;

  logic          f_valid;
  pix_t          f_pix;
  logic [RW-1:0] f_dividend;

  logic          d_valid;
  pix_t          d_pix;
  logic [QW-1:0] d_quo;

  // whole pipeline moves when the output register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  hrot_cfg #(
    .FULL (FULL),
    .HW   (HW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rot_off   (rot_off),
    .shift_mod (shift_mod)
  );

  hrot_front #(
    .SIXTH (SIXTH),
    .RW    (RW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (s_tvalid),
    .in_data      (s_tdata),
    .rot_off      (rot_off),
    .out_valid    (f_valid),
    .out_pix      (f_pix),
    .out_dividend (f_dividend)
  );

  hrot_div #(
    .QW (QW),
    .RW (RW)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (f_valid),
    .in_pix      (f_pix),
    .in_dividend (f_dividend),
    .out_valid   (d_valid),
    .out_pix     (d_pix),
    .out_quo     (d_quo)
  );

  hrot_back #(
    .F     (HUE_FRAC_BITS),
    .SIXTH (SIXTH),
    .FULL  (FULL),
    .QW    (QW),
    .HW    (HW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_pix    (d_pix),
    .in_quo    (d_quo),
    .shift_mod (shift_mod),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_flag  (m_tuser)
  );

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the rgb hue rotator
`timescale 1ns / 1ps
module tb_top;
  import hrot_pkg::*;

  localparam int UNIT  = 16;
  localparam int SIXTH = 60 * UNIT;
  localparam int FULL  = 360 * UNIT;
  localparam int LATENCY = 21;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       bypass;
  } pixel_t;

  // directed stimulus row: config to apply, pixel, optional typed expectation
  typedef struct {
    int   shift;
    bit   en;
    logic [7:0] r, g, b;
    bit   typed;
    pixel_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  rgb_hue_rotate u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic [13:0] shift_reg = '0;
  bit          enable_reg = 1'b1;

  pixel_t rotated_q[$];
  int     errors = 0;
  int     cycles = 0;
  int     sent = 0, received = 0, bypassed = 0;
  int     send_idle = 0, recv_stall = 0;
  bit     hold_off = 1'b0;

  // hue rotation predictor
  function automatic pixel_t rotate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int mx, mn, d, num, h, sh, t, w, mid;
    pixel_t p;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sh = $signed(shift_reg);
    p = '{r: r, g: g, b: b, bypass: 1'b1};
    if (sh == 0 || !enable_reg || mx == 0 || mn == 255 || 100 * d < mx || d == 0)
      return p;
    if (mx == r) num = 6 * d + g - b;
    else if (mx == g) num = 2 * d + b - r;
    else num = 4 * d + r - g;
    h = num * SIXTH / d;
    if (h >= FULL) h -= FULL;
    sh = sh % FULL;
    if (sh < 0) sh += FULL;
    h = (h + sh) % FULL;
    t = h % (2 * SIXTH);
    w = (t < SIXTH) ? t : 2 * SIXTH - t;
    mid = mn + d * w / SIXTH;
    case (sector_t'(h / SIXTH))
      SEC_RED_UP:   p = '{r: mx,  g: mid, b: mn,  bypass: 1'b0};
      SEC_GRN_DOWN: p = '{r: mid, g: mx,  b: mn,  bypass: 1'b0};
      SEC_GRN_UP:   p = '{r: mn,  g: mx,  b: mid, bypass: 1'b0};
      SEC_BLU_DOWN: p = '{r: mn,  g: mid, b: mx,  bypass: 1'b0};
      SEC_BLU_UP:   p = '{r: mid, g: mn,  b: mx,  bypass: 1'b0};
      default:      p = '{r: mx,  g: mn,  b: mid, bypass: 1'b0};
    endcase
    return p;
  endfunction

  // register write over the config port, only while idle
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == REG_HUE_SHIFT) shift_reg = data[13:0];
    else if (addr == REG_ENABLE) enable_reg = data[0];
  endtask

  task automatic drain;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_config(int shift, bit en);
    drain();
    write_reg(REG_HUE_SHIFT, 32'(shift));
    write_reg(REG_ENABLE, {31'd0, en});
  endtask

  // one pixel transfer on the input side, with optional idle gap
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit typed,
                            pixel_t want);
    pixel_t p;
    @(negedge clk);
    // each cycle idles with the set probability
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    p = rotate_pixel(r, g, b);
    if (typed && p != want) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, want, p);
      errors++;
    end
    s_tdata = {b, g, r};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rotated_q.push_back(p);
    sent++;
    #1 s_tvalid = 1'b0;
  endtask

  // output side: stalls and checks
  always @(negedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    pixel_t exp_p;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (rotated_q.size() == 0) begin
        $display("%0t unexpected pixel: expected none actual %h %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_p = rotated_q.pop_front();
        received++;
        if (exp_p.bypass) bypassed++;
        if (m_tdata[7:0] !== exp_p.r)
          $display("%0t red: expected %0d actual %0d", $time, exp_p.r, m_tdata[7:0]);
        if (m_tdata[15:8] !== exp_p.g)
          $display("%0t green: expected %0d actual %0d", $time, exp_p.g, m_tdata[15:8]);
        if (m_tdata[23:16] !== exp_p.b)
          $display("%0t blue: expected %0d actual %0d", $time, exp_p.b, m_tdata[23:16]);
        if (m_tuser !== exp_p.bypass)
          $display("%0t bypass: expected %0d actual %0d", $time, exp_p.bypass, m_tuser);
        if (m_tdata !== {exp_p.b, exp_p.g, exp_p.r} || m_tuser !== exp_p.bypass) errors++;
      end
    end
  end

  // random pixel, biased toward saturated colors and edge values
  task automatic send_random;
    logic [7:0] c[3];
    int k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(5))
        0: c[k] = 8'd0;
        1: c[k] = 8'd255;
        default: c[k] = 8'($urandom);
      endcase
    end
    send_pixel(c[0], c[1], c[2], 1'b0, '0);
  endtask

  row_t rows[$];
  int   shifts[] = '{0, 5760, -5760, 8191, -8192, 1, -1, 960, 2880, -1234};
  int   i, j, ph;

  initial begin
    // directed table
    rows.push_back('{0, 1, 8'd255, 8'd0, 8'd0, 1, '{8'd255, 8'd0, 8'd0, 1'b1}});
    rows.push_back('{960, 1, 8'd0, 8'd0, 8'd0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}});
    rows.push_back('{960, 1, 8'd255, 8'd255, 8'd255, 1, '{8'd255, 8'd255, 8'd255, 1'b1}});
    rows.push_back('{960, 1, 8'd77, 8'd77, 8'd77, 1, '{8'd77, 8'd77, 8'd77, 1'b1}});
    rows.push_back('{960, 1, 8'd200, 8'd199, 8'd199, 1, '{8'd200, 8'd199, 8'd199, 1'b1}});
    rows.push_back('{960, 1, 8'd255, 8'd0, 8'd0, 0, '0});
    rows.push_back('{960, 1, 8'd0, 8'd255, 8'd0, 0, '0});
    rows.push_back('{960, 1, 8'd0, 8'd0, 8'd255, 0, '0});
    rows.push_back('{960, 1, 8'd100, 8'd99, 8'd0, 0, '0});
    rows.push_back('{960, 0, 8'd255, 8'd0, 8'd0, 1, '{8'd255, 8'd0, 8'd0, 1'b1}});
    rows.push_back('{5760, 1, 8'd255, 8'd128, 8'd1, 0, '0});
    rows.push_back('{-5760, 1, 8'd13, 8'd200, 8'd90, 0, '0});
    rows.push_back('{8191, 1, 8'd255, 8'd255, 8'd0, 0, '0});
    rows.push_back('{-8192, 1, 8'd1, 8'd254, 8'd255, 0, '0});
    rows.push_back('{1, 1, 8'd255, 8'd0, 8'd255, 0, '0});
    rows.push_back('{-1, 1, 8'd101, 8'd100, 8'd0, 0, '0});
    rows.push_back('{2880, 1, 8'd170, 8'd85, 8'd255, 0, '0});
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].shift != $signed(shift_reg) || rows[i].en != enable_reg)
        set_config(rows[i].shift, rows[i].en);
      send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].typed, rows[i].want);
    end
    // random phases over idle patterns and settings
    for (ph = 0; ph < 8; ph++) begin
      set_config(shifts[$urandom_range(shifts.size() - 1)], ($urandom_range(7) != 0));
      if (ph == 1) set_config($urandom_range(16383) - 8192, 1'b1);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      if (ph == 2) begin
        // long receiver hold-off while input keeps coming
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
          for (j = 0; j < 60; j++) send_random();
        join
      end
      for (j = 0; j < 100; j++) send_random();
      // pause until all pending pixels are out
      while (rotated_q.size() != 0) @(posedge clk);
    end
    send_idle = 0; recv_stall = 0;
    drain();
    $display("sent %0d pixels, received %0d, %0d bypassed; shifts to +/-full turn and",
             sent, received, bypassed);
    $display("beyond, enable on and off, with input gaps and output stalls");
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
